// File: rtl/kbts_pkg.sv
// Package for the keyframe bone transform sampler.
// Holds request and result types, codes, state encoding and Q16.16 helpers.
// No dependencies.
`default_nettype none

package kbts_pkg;

  localparam int KEY_SLOTS_DEFAULT = 16;

  localparam logic signed [31:0] QOne = 32'sd65536;

  localparam logic [0:0] RegKeyCount = 1'b0;

  typedef enum logic [2:0] {
    OP_SAMPLE   = 3'd0,
    OP_WR_TIME  = 3'd1,
    OP_WR_SCALE = 3'd2,
    OP_WR_MOVE  = 3'd3,
    OP_WR_ROT   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    PART_SCALE = 2'd0,
    PART_MOVE  = 2'd1,
    PART_ROT   = 2'd2
  } part_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DIV,
    ST_ATTR_A,
    ST_ATTR_B,
    ST_LERP_MUL,
    ST_LERP_ACC,
    ST_QM_MUL,
    ST_QM_ACC,
    ST_WAIT_OUT,
    ST_FIN_MUL,
    ST_FIN_ACC
  } state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [3:0]         key_index;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
  } kbts_req_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic signed [31:0] elem_3;
    logic               last_row;
  } kbts_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/kbts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the key time and key attribute stores. No dependencies.
`default_nettype none

module kbts_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/keyframe_bone_transform_sampler.sv
// Keyframe bone transform sampler: a write request stores one part of one key.
// A sample request scans the key time memory over the n active keys, word by
// word with a read state and a check state per word, and when the time falls
// between two keys it divides the fraction out with the bit-serial divider. A
// single shared 33x33 multiplier computes each of the 28 products of a sample,
// with a multiply state and an accumulate state per product. While a sample is
// in progress no request is taken; the four result rows sit in an output
// register, so the next request is accepted while they drain.
// Depends on kbts_pkg and kbts_ram.
`default_nettype none

module keyframe_bone_transform_sampler #(
  parameter int KEY_SLOTS = kbts_pkg::KEY_SLOTS_DEFAULT
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  kbts_pkg::kbts_req_t    in_req_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output kbts_pkg::kbts_rsp_t    out_rsp_o,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire [2:0]              paddr,
  input  wire [31:0]             pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  import kbts_pkg::*;

  localparam int SW = $clog2(KEY_SLOTS);
  localparam int AW = SW + 2;

  state_e state_q, state_d;
  logic [4:0] key_count_q;
  logic [SW-1:0] last_idx;

  logic t_we, t_re, a_we, a_re;
  logic [AW-1:0] a_waddr, a_raddr;
  logic [31:0] t_rdata;
  logic [127:0] a_rdata;
  logic slot_ok, in_accept, out_accept;

  logic signed [31:0] t_q, prev_q, cur;
  logic [SW-1:0] idx_q, k0_q, k1_q;
  logic below_q, found_q, below_now, hit, found_now, ge_last, go_div;
  logic [32:0] rem_q, den_q;
  logic [33:0] rem_sh;
  logic rem_ge;
  logic [15:0] f_q;
  logic [3:0] dcnt_q;

  part_e part_q;
  logic [1:0] comp_q, comp_last;
  logic [127:0] row_a_q;
  logic signed [31:0] comp_a, comp_b;
  logic signed [33:0] lerp_sum;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  logic signed [31:0] s_q [3];
  logic signed [31:0] p_q [3];
  logic signed [31:0] q_q [4];
  logic signed [47:0] qm_q [9];
  logic [3:0] qop_q;

  logic [1:0] frow_q, fcol_q;
  logic [3:0] fidx_q;
  logic signed [50:0] d_xx, d_yy, d_zz, d_xy, d_xz, d_yz, d_xw, d_yw, d_zw, one51;
  logic signed [50:0] rot_sel;

  logic signed [31:0] out_e_q [9];
  logic signed [31:0] out_p_q [3];
  logic out_busy_q;
  logic [1:0] orow_q;

  always_comb begin
    if (key_count_q == 5'd0) begin
      last_idx = '0;
    end else if (32'(key_count_q) > KEY_SLOTS) begin
      last_idx = SW'(KEY_SLOTS - 1);
    end else begin
      last_idx = SW'(key_count_q - 5'd1);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegKeyCount) ? {27'd0, key_count_q} : 32'd0;

  assign slot_ok    = 32'(in_req_i.key_index) < KEY_SLOTS;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign out_accept = out_valid_o && !out_stall_i;

  kbts_ram #(.Width(32), .Depth(KEY_SLOTS)) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(SW'(in_req_i.key_index)),
    .wdata_i(in_req_i.value_0),
    .re_i   (t_re),
    .raddr_i(idx_q),
    .rdata_o(t_rdata)
  );

  kbts_ram #(.Width(128), .Depth(4 * KEY_SLOTS)) u_attr_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(a_waddr),
    .wdata_i({in_req_i.value_3, in_req_i.value_2, in_req_i.value_1, in_req_i.value_0}),
    .re_i   (a_re),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  // Interval scan terms for the key time that arrives this cycle.
  assign cur       = $signed(t_rdata);
  assign below_now = (idx_q == '0) ? (t_q < cur) : below_q;
  assign hit       = (idx_q != '0) && (prev_q <= t_q) && (t_q < cur);
  assign found_now = found_q || hit;
  assign ge_last   = (t_q >= cur);
  assign go_div    = !below_now && !ge_last && found_now;

  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  assign comp_a    = $signed(row_a_q[32*comp_q +: 32]);
  assign comp_b    = $signed(a_rdata[32*comp_q +: 32]);
  assign comp_last = (part_q == PART_ROT) ? 2'd3 : 2'd2;
  assign lerp_sum  = 34'(comp_a) + $signed(prod_q[49:16]);

  assign one51 = 51'(QOne);
  assign d_xx  = 51'(qm_q[0]) <<< 1;
  assign d_yy  = 51'(qm_q[1]) <<< 1;
  assign d_zz  = 51'(qm_q[2]) <<< 1;
  assign d_xy  = 51'(qm_q[3]) <<< 1;
  assign d_xz  = 51'(qm_q[4]) <<< 1;
  assign d_yz  = 51'(qm_q[5]) <<< 1;
  assign d_xw  = 51'(qm_q[6]) <<< 1;
  assign d_yw  = 51'(qm_q[7]) <<< 1;
  assign d_zw  = 51'(qm_q[8]) <<< 1;

  always_comb begin
    case ({frow_q, fcol_q})
      4'b0000: rot_sel = one51 - d_yy - d_zz;
      4'b0001: rot_sel = d_xy + d_zw;
      4'b0010: rot_sel = d_xz - d_yw;
      4'b0100: rot_sel = d_xy - d_zw;
      4'b0101: rot_sel = one51 - d_xx - d_zz;
      4'b0110: rot_sel = d_yz + d_xw;
      4'b1000: rot_sel = d_xz + d_yw;
      4'b1001: rot_sel = d_yz - d_xw;
      4'b1010: rot_sel = one51 - d_xx - d_yy;
      default: rot_sel = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    t_we    = 1'b0;
    t_re    = 1'b0;
    a_we    = 1'b0;
    a_re    = 1'b0;
    a_waddr = {SW'(in_req_i.key_index), PART_SCALE};
    a_raddr = {k0_q, part_q};
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (op_e'(in_req_i.operation))
            OP_SAMPLE:   state_d = ST_SCAN_RD;
            OP_WR_TIME:  t_we = slot_ok;
            OP_WR_SCALE: a_we = slot_ok;
            OP_WR_MOVE: begin
              a_we    = slot_ok;
              a_waddr = {SW'(in_req_i.key_index), PART_MOVE};
            end
            OP_WR_ROT: begin
              a_we    = slot_ok;
              a_waddr = {SW'(in_req_i.key_index), PART_ROT};
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD: begin
        t_re    = 1'b1;
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (idx_q == last_idx) begin
          state_d = go_div ? ST_DIV : ST_ATTR_A;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_DIV: begin
        if (dcnt_q == 4'd15) begin
          state_d = ST_ATTR_A;
        end
      end
      ST_ATTR_A: begin
        a_re    = 1'b1;
        state_d = ST_ATTR_B;
      end
      ST_ATTR_B: begin
        a_re    = 1'b1;
        a_raddr = {k1_q, part_q};
        state_d = ST_LERP_MUL;
      end
      ST_LERP_MUL: begin
        mul_a   = 33'(comp_b) - 33'(comp_a);
        mul_b   = $signed({17'd0, f_q});
        state_d = ST_LERP_ACC;
      end
      ST_LERP_ACC: begin
        if (comp_q == comp_last) begin
          state_d = (part_q == PART_ROT) ? ST_QM_MUL : ST_ATTR_A;
        end else begin
          state_d = ST_LERP_MUL;
        end
      end
      ST_QM_MUL: begin
        case (qop_q)
          4'd0: begin mul_a = 33'(q_q[0]); mul_b = 33'(q_q[0]); end
          4'd1: begin mul_a = 33'(q_q[1]); mul_b = 33'(q_q[1]); end
          4'd2: begin mul_a = 33'(q_q[2]); mul_b = 33'(q_q[2]); end
          4'd3: begin mul_a = 33'(q_q[0]); mul_b = 33'(q_q[1]); end
          4'd4: begin mul_a = 33'(q_q[0]); mul_b = 33'(q_q[2]); end
          4'd5: begin mul_a = 33'(q_q[1]); mul_b = 33'(q_q[2]); end
          4'd6: begin mul_a = 33'(q_q[0]); mul_b = 33'(q_q[3]); end
          4'd7: begin mul_a = 33'(q_q[1]); mul_b = 33'(q_q[3]); end
          4'd8: begin mul_a = 33'(q_q[2]); mul_b = 33'(q_q[3]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        state_d = ST_QM_ACC;
      end
      ST_QM_ACC: begin
        state_d = (qop_q == 4'd8) ? ST_WAIT_OUT : ST_QM_MUL;
      end
      ST_WAIT_OUT: begin
        if (!out_busy_q) begin
          state_d = ST_FIN_MUL;
        end
      end
      ST_FIN_MUL: begin
        mul_a   = 33'(s_q[frow_q]);
        mul_b   = 33'(sat32(64'(rot_sel)));
        state_d = ST_FIN_ACC;
      end
      ST_FIN_ACC: begin
        state_d = (fidx_q == 4'd8) ? ST_IDLE : ST_FIN_MUL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_count_q <= 5'd1;
      out_busy_q  <= 1'b0;
      orow_q      <= 2'd0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && (paddr[2] == RegKeyCount)) begin
        key_count_q <= pwdata[4:0];
      end
      if (state_q == ST_FIN_ACC && fidx_q == 4'd8) begin
        out_busy_q <= 1'b1;
        orow_q     <= 2'd0;
      end else if (out_accept) begin
        if (orow_q == 2'd3) begin
          out_busy_q <= 1'b0;
        end
        orow_q <= orow_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        t_q     <= in_req_i.value_0;
        idx_q   <= '0;
        found_q <= 1'b0;
      end
      ST_SCAN_CHK: begin
        prev_q  <= cur;
        below_q <= below_now;
        found_q <= found_now;
        if (hit) begin
          k0_q  <= idx_q - 1'b1;
          rem_q <= $unsigned(33'(t_q) - 33'(prev_q));
          den_q <= $unsigned(33'(cur) - 33'(prev_q));
        end
        if (idx_q != last_idx) begin
          idx_q <= idx_q + 1'b1;
        end else begin
          f_q    <= '0;
          dcnt_q <= '0;
          part_q <= PART_SCALE;
          comp_q <= 2'd0;
          if (below_now) begin
            k0_q <= '0;
            k1_q <= '0;
          end else if (!go_div) begin
            k0_q <= last_idx;
            k1_q <= last_idx;
          end else begin
            k1_q <= hit ? idx_q : k0_q + 1'b1;
          end
        end
      end
      ST_DIV: begin
        rem_q  <= rem_ge ? 33'(rem_sh - {1'b0, den_q}) : rem_sh[32:0];
        f_q    <= {f_q[14:0], rem_ge};
        dcnt_q <= dcnt_q + 4'd1;
      end
      ST_ATTR_B: begin
        row_a_q <= a_rdata;
      end
      ST_LERP_ACC: begin
        case (part_q)
          PART_SCALE: s_q[comp_q] <= lerp_sum[31:0];
          PART_MOVE:  p_q[comp_q] <= lerp_sum[31:0];
          default:    q_q[comp_q] <= lerp_sum[31:0];
        endcase
        qop_q <= 4'd0;
        if (comp_q == comp_last) begin
          comp_q <= 2'd0;
          part_q <= (part_q == PART_SCALE) ? PART_MOVE : PART_ROT;
        end else begin
          comp_q <= comp_q + 2'd1;
        end
      end
      ST_QM_ACC: begin
        qm_q[qop_q] <= prod_q[63:16];
        qop_q       <= qop_q + 4'd1;
      end
      ST_WAIT_OUT: begin
        frow_q <= 2'd0;
        fcol_q <= 2'd0;
        fidx_q <= 4'd0;
        if (!out_busy_q) begin
          out_p_q <= p_q;
        end
      end
      ST_FIN_ACC: begin
        out_e_q[fidx_q] <= sat32(64'($signed(prod_q[65:16])));
        fidx_q          <= fidx_q + 4'd1;
        if (fcol_q == 2'd2) begin
          fcol_q <= 2'd0;
          frow_q <= frow_q + 2'd1;
        end else begin
          fcol_q <= fcol_q + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_busy_q;

  always_comb begin
    out_rsp_o.row_index = orow_q;
    out_rsp_o.last_row  = (orow_q == 2'd3);
    out_rsp_o.elem_3    = '0;
    case (orow_q)
      2'd0: begin
        out_rsp_o.elem_0 = out_e_q[0];
        out_rsp_o.elem_1 = out_e_q[1];
        out_rsp_o.elem_2 = out_e_q[2];
      end
      2'd1: begin
        out_rsp_o.elem_0 = out_e_q[3];
        out_rsp_o.elem_1 = out_e_q[4];
        out_rsp_o.elem_2 = out_e_q[5];
      end
      2'd2: begin
        out_rsp_o.elem_0 = out_e_q[6];
        out_rsp_o.elem_1 = out_e_q[7];
        out_rsp_o.elem_2 = out_e_q[8];
      end
      default: begin
        out_rsp_o.elem_0 = out_p_q[0];
        out_rsp_o.elem_1 = out_p_q[1];
        out_rsp_o.elem_2 = out_p_q[2];
        out_rsp_o.elem_3 = QOne;
      end
    endcase
  end

  a_div_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_div_adjacent_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (k1_q == k0_q + 1'b1))
    else $error("interpolation keys not adjacent");

  a_fin_output_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN_MUL || state_q == ST_FIN_ACC) |-> !out_busy_q)
    else $error("matrix computed while previous rows still pending");

  a_last_row_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && out_rsp_o.last_row) |=> !out_valid_o)
    else $error("result still valid after last row taken");

endmodule

`default_nettype wire
